FILE: design/b58e_pkg.sv
package b58e_pkg;

  localparam int unsigned MAX_BYTES  = 32;
  localparam int unsigned MAX_DIGITS = 44;
  localparam int unsigned RESULT_CAP = 44;

  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned CARRY_W = 9;
  localparam int unsigned SUM_W   = 14;
  localparam int unsigned RECIP_W = 25;
  localparam int unsigned RECIP_SH = 16;

  localparam logic [10:0] RECIP_58 = 11'd1130;
  localparam logic [6:0]  CHAR_ONE = 7'd49;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       is_last;
  } b58e_in_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last_char;
    logic       overflow;
  } b58e_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABSORB,
    ST_PREP,
    ST_ONES,
    ST_DIGITS
  } b58e_state_t;

  function automatic logic [6:0] b58e_alpha(input logic [DIGIT_W-1:0] d);
    logic [5:0] v;
    logic [6:0] c;
    v = (d >= 6'd58) ? d - 6'd58 : d;
    if (v < 6'd9) begin
      c = 7'd49 + {1'b0, v};
    end else if (v < 6'd17) begin
      c = 7'd56 + {1'b0, v};
    end else if (v < 6'd22) begin
      c = 7'd57 + {1'b0, v};
    end else if (v < 6'd33) begin
      c = 7'd58 + {1'b0, v};
    end else if (v < 6'd44) begin
      c = 7'd64 + {1'b0, v};
    end else begin
      c = 7'd65 + {1'b0, v};
    end
    return c;
  endfunction

endpackage

FILE: design/base58_encoder_unit.sv
// Each byte runs an absorb pass that steps once through every stored base-58 digit and once
// per new digit; the carry pass through the shared divide-by-58 unit sets its length.
// On the last byte, a setup step (ST_PREP), then one character per cycle (at most 44), no stalls.
// A new byte is taken only once the last one is through; busy stays high meanwhile.
// Reset (rst_n low, synchronous) clears the sequencer and the message state; the digit
// memory needs no clearing pass.
module base58_encoder_unit
  import b58e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  b58e_in_t  in_data,
  output logic      out_strobe,
  output b58e_out_t out_data
);

  b58e_state_t state_r, state_nxt;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rdata_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [DIGIT_W-1:0] wr_data;
  logic               mem_we;

  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   zpc_r, zpc_nxt;
  logic               in_prefix_r, in_prefix_nxt;
  logic [IDX_W-1:0]   bytes_r, bytes_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_r, last_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   ones_r, ones_nxt;
  logic [IDX_W-1:0]   ones_tgt_r, ones_tgt_nxt;
  logic               lost_r, lost_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  b58e_out_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               room;
  logic               in_digits;
  logic               grow;
  logic               absorb_done;
  logic [DIGIT_W-1:0] d_eff;
  logic [SUM_W-1:0]   x;
  logic [RECIP_W-1:0] prod;
  logic [CARRY_W-1:0] q;
  logic [SUM_W-1:0]   r_full;
  logic               cap_hit;
  logic               ones_end;
  logic               emit_final;
  logic [IDX_W-1:0]   ones_need;
  logic [CNT_W-1:0]   total;
  logic [IDX_W-1:0]   j_inc;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign room      = (bytes_r < IDX_W'(MAX_BYTES));
  assign in_digits = (j_r < cnt_r);
  assign grow      = !in_digits && (carry_r != '0) && (cnt_r < IDX_W'(MAX_DIGITS));
  assign absorb_done = !in_digits && !grow;
  assign j_inc     = j_r + IDX_W'(1);

  // shared divide-by-58 unit
  assign d_eff  = ((bytes_r == IDX_W'(1)) && (j_r == '0)) ? '0 : rdata_r;
  assign x      = in_digits ? (SUM_W'(carry_r) + {d_eff, 8'b0}) : SUM_W'(carry_r);
  assign prod   = RECIP_W'(x) * RECIP_W'(RECIP_58);
  assign q      = prod[RECIP_SH +: CARRY_W];
  assign r_full = x - (SUM_W'(q) * SUM_W'(58));

  assign cap_hit    = (n_r == IDX_W'(RESULT_CAP - 1));
  assign ones_end   = (ones_r == ones_tgt_r - IDX_W'(1));
  assign emit_final = ((state_r == ST_ONES) && (cap_hit || (ones_end && in_prefix_r))) ||
                      ((state_r == ST_DIGITS) && (cap_hit || (idx_r == '0)));
  assign ones_need  = (in_prefix_r && (zpc_r == '0)) ? IDX_W'(1) : zpc_r;
  assign total = CNT_W'(ones_need) + (in_prefix_r ? CNT_W'(0) : CNT_W'(cnt_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            state_nxt = ST_ABSORB;
          end else if (in_data.is_last) begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_ABSORB: begin
        if (absorb_done) begin
          state_nxt = last_r ? ST_PREP : ST_IDLE;
        end
      end
      ST_PREP: begin
        state_nxt = (ones_need == '0) ? ST_DIGITS : ST_ONES;
      end
      ST_ONES: begin
        if (emit_final) begin
          state_nxt = ST_IDLE;
        end else if (ones_end) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (emit_final) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    zpc_nxt        = zpc_r;
    in_prefix_nxt  = in_prefix_r;
    bytes_nxt      = bytes_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    carry_nxt      = carry_r;
    j_nxt          = j_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    ones_nxt       = ones_r;
    ones_tgt_nxt   = ones_tgt_r;
    lost_nxt       = lost_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    rd_addr        = '0;
    wr_addr        = j_r;
    wr_data        = r_full[DIGIT_W-1:0];
    mem_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          last_nxt = in_data.is_last;
          if (room) begin
            if (!(in_prefix_r && (in_data.byte_in == 8'd0))) begin
              in_prefix_nxt = 1'b0;
            end else begin
              zpc_nxt = zpc_r + IDX_W'(1);
            end
            bytes_nxt = bytes_r + IDX_W'(1);
            carry_nxt = CARRY_W'(in_data.byte_in);
            j_nxt     = '0;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_ABSORB: begin
        rd_addr = (j_inc < IDX_W'(MAX_DIGITS)) ? j_inc : '0;
        if (in_digits || grow) begin
          mem_we    = 1'b1;
          carry_nxt = q;
          j_nxt     = j_inc;
          if (grow) begin
            cnt_nxt = cnt_r + IDX_W'(1);
          end
        end else if (carry_r != '0) begin
          ovf_nxt = 1'b1;
        end
      end
      ST_PREP: begin
        ones_tgt_nxt = ones_need;
        lost_nxt     = ovf_r || (total > CNT_W'(RESULT_CAP));
        idx_nxt      = cnt_r - IDX_W'(1);
        rd_addr      = cnt_r - IDX_W'(1);
        n_nxt        = '0;
        ones_nxt     = '0;
      end
      ST_ONES: begin
        rd_addr        = idx_r;
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{char_out: CHAR_ONE, last_char: emit_final, overflow: lost_r};
        ones_nxt       = ones_r + IDX_W'(1);
        n_nxt          = n_r + IDX_W'(1);
      end
      ST_DIGITS: begin
        rd_addr        = idx_r - IDX_W'(1);
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '{char_out: b58e_alpha(rdata_r), last_char: emit_final,
                           overflow: lost_r};
        idx_nxt        = idx_r - IDX_W'(1);
        n_nxt          = n_r + IDX_W'(1);
      end
      default: ;
    endcase
    // drop the message state once the last character is out
    if (emit_final) begin
      cnt_nxt       = IDX_W'(1);
      zpc_nxt       = '0;
      in_prefix_nxt = 1'b1;
      bytes_nxt     = '0;
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= IDX_W'(1);
      zpc_r        <= '0;
      in_prefix_r  <= 1'b1;
      bytes_r      <= '0;
      ovf_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      zpc_r        <= zpc_nxt;
      in_prefix_r  <= in_prefix_nxt;
      bytes_r      <= bytes_nxt;
      ovf_r        <= ovf_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    carry_r    <= carry_nxt;
    j_r        <= j_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    ones_r     <= ones_nxt;
    ones_tgt_r <= ones_tgt_nxt;
    lost_r     <= lost_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

FILE: bench/base58_encoder_unit_test.sv
`timescale 1ns / 100ps

module base58_encoder_unit_test
  import b58e_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 60;
  localparam int unsigned RANDOM_BYTES = 300;
  localparam int unsigned BURST_BYTES = 40;
  localparam int unsigned REPORT_LIMIT = 40;
  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  b58e_in_t  in_data = '0;
  logic      out_strobe;
  b58e_out_t out_data;

  logic [DIGIT_W-1:0] number_digits [MAX_DIGITS];
  int unsigned        number_len;
  int unsigned        zero_lead;
  int unsigned        bytes_taken;
  bit                 in_lead;
  bit                 bytes_lost;

  b58e_out_t   expected_chars[$];
  logic [7:0]  message_bytes[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;

  base58_encoder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("base58_encoder_unit_test failed");
      $finish;
    end
  end

  function automatic void clear_number();
    for (int i = 0; i < MAX_DIGITS; i++) begin
      number_digits[i] = '0;
    end
    number_len  = 1;
    zero_lead   = 0;
    bytes_taken = 0;
    in_lead     = 1'b1;
    bytes_lost  = 1'b0;
  endfunction

  // multiply the base-58 number by 256 and add the byte
  function automatic void fold_byte(input logic [7:0] b);
    int unsigned carry;
    carry = 32'(b);
    if (in_lead && b == 8'd0) begin
      zero_lead++;
    end else begin
      in_lead = 1'b0;
    end
    for (int j = 0; j < number_len && j < MAX_DIGITS; j++) begin
      carry = carry + 256 * 32'(number_digits[j]);
      number_digits[j] = DIGIT_W'(carry % 58);
      carry = carry / 58;
    end
    while (carry != 0) begin
      if (number_len >= MAX_DIGITS) begin
        bytes_lost = 1'b1;
        break;
      end
      number_digits[number_len] = DIGIT_W'(carry % 58);
      number_len++;
      carry = carry / 58;
    end
    bytes_taken++;
  endfunction

  function automatic void encode_transaction(input b58e_in_t txn);
    logic [6:0]  codes[$];
    b58e_out_t   c;
    bit          lost;
    bit          all_zero;
    int unsigned d;
    if (bytes_taken < MAX_BYTES) begin
      fold_byte(txn.byte_in);
    end else begin
      bytes_lost = 1'b1;
    end
    if (!txn.is_last) begin
      return;
    end
    lost = bytes_lost;
    for (int i = 0; i < zero_lead; i++) begin
      if (codes.size() >= RESULT_CAP) begin
        lost = 1'b1;
        break;
      end
      codes.push_back(CHAR_ONE);
    end
    all_zero = (number_len <= 1) && (number_digits[0] == '0);
    if (!all_zero) begin
      for (int i = number_len; i > 0; i--) begin
        if (codes.size() >= RESULT_CAP) begin
          lost = 1'b1;
          break;
        end
        d = 32'(number_digits[i-1]);
        codes.push_back(ALPHABET[8*(57-d) +: 7]);
      end
    end
    if (codes.size() == 0) begin
      codes.push_back(CHAR_ONE);
    end
    for (int i = 0; i < codes.size(); i++) begin
      c.char_out  = codes[i];
      c.last_char = (i == codes.size() - 1);
      c.overflow  = lost;
      expected_chars.push_back(c);
    end
    clear_number();
  endfunction

  always @(posedge clk) begin
    b58e_out_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: unexpected character: expected none, actual char=%h last=%b ovf=%b",
                   $time, out_data.char_out, out_data.last_char, out_data.overflow);
        end
      end else begin
        want = expected_chars.pop_front();
        if (out_data.char_out !== want.char_out || out_data.last_char !== want.last_char ||
            out_data.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: mismatch: expected char=%h last=%b ovf=%b, actual char=%h last=%b ovf=%b",
                     $time, want.char_out, want.last_char, want.overflow,
                     out_data.char_out, out_data.last_char, out_data.overflow);
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    b58e_in_t txn;
    txn.byte_in = b;
    txn.is_last = last;
    in_data <= txn;
    start   <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    encode_transaction(txn);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_message();
    for (int i = 0; i < message_bytes.size(); i++) begin
      send_byte(message_bytes[i], i == message_bytes.size() - 1);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic build_random_message();
    int unsigned len;
    int unsigned nzero;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = $urandom_range(1, 6);
    end else if (pick < 90) begin
      len = $urandom_range(7, MAX_BYTES);
    end else begin
      len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 4);
    end
    nzero = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
    message_bytes.delete();
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (i < nzero || pick == 0) begin
        message_bytes.push_back(8'h00);
      end else if (pick == 1) begin
        message_bytes.push_back(8'hFF);
      end else begin
        message_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_single_byte_messages();
    message_bytes = '{8'h00};
    send_message();
    message_bytes = '{8'h01};
    send_message();
    message_bytes = '{8'hFF};
    send_message();
  endtask

  task automatic test_leading_zero_bytes();
    message_bytes = '{8'h00, 8'h00, 8'h00};
    send_message();
    message_bytes = '{8'h00, 8'h00, 8'h01};
    send_message();
    message_bytes = '{8'h01, 8'h00};
    send_message();
  endtask

  // full-size number, then a dropped byte that ends the message
  task automatic test_byte_overflow();
    message_bytes.delete();
    repeat (MAX_BYTES) message_bytes.push_back(8'hFF);
    message_bytes.push_back(8'h00);
    send_message();
  endtask

  task automatic test_send_after_drain();
    message_bytes = '{8'h12, 8'h34, 8'h56};
    send_message();
    wait_drained();
    message_bytes = '{8'hAB};
    send_message();
  endtask

  task automatic test_random_messages(input int unsigned count);
    int unsigned total;
    total = 0;
    while (total < count) begin
      build_random_message();
      total += message_bytes.size();
      send_message();
      if ($urandom_range(0, 9) == 0) begin
        wait_drained();
      end
    end
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    test_random_messages(BURST_BYTES);
  endtask

  initial begin
    clear_number();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_byte_messages();
    test_leading_zero_bytes();
    test_byte_overflow();
    test_send_after_drain();
    test_random_messages(RANDOM_BYTES);
    test_back_to_back();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("base58_encoder_unit_test passed");
    end else begin
      $display("base58_encoder_unit_test failed");
    end
    $finish;
  end

endmodule
